/* rtl/core/dikvs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dikvs_pkg
// Shared types, codes and defaults for the direct indexed key-value store.
// ----------------------------------------------------------------------------
package dikvs_pkg;

  localparam int DefTableEntries = 1024;
  localparam int DefValueWords   = 16;

  localparam logic [7:0]  LEN_AT_RESET   = 8'd128;
  localparam logic [23:0] LIMIT_AT_RESET = 24'd435000;

  localparam logic [2:0] KIND_TICK       = 3'd0;
  localparam logic [2:0] KIND_GET        = 3'd1;
  localparam logic [2:0] KIND_GET_RESEND = 3'd2;
  localparam logic [2:0] KIND_DELETE     = 3'd3;
  localparam logic [2:0] KIND_PUT_HIT    = 3'd4;
  localparam logic [2:0] KIND_PUT_MISS   = 3'd5;

  typedef enum logic [2:0] {
    RESP_GET_FAIL = 3'd0,
    RESP_GET_OK   = 3'd1,
    RESP_DEL_FAIL = 3'd2,
    RESP_DEL_OK   = 3'd3,
    RESP_PUT_FAIL = 3'd4,
    RESP_PUT_HIT  = 3'd5,
    RESP_PUT_MISS = 3'd6
  } resp_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key_number;
    logic        object_locked;
    logic [7:0]  put_length;
    logic [3:0]  word_index;
    logic [63:0] value_word;
  } req_t;

  typedef struct packed {
    logic [2:0]  response;
    logic [31:0] reply_key;
    logic [7:0]  reply_length;
    logic [63:0] reply_word;
    logic        last_word;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic  clr_step;
    logic  capture;
    logic  tick_clear;
    logic  rate_inc;
    logic  put_close;
    logic  cont_wr;
    logic  put_open;
    logic  len_clr;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  emit;
    resp_e resp;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic is_tick;
    logic is_cont;
    logic cont_skip;
    logic cont_hit;
    logic key_bad;
    logic rate_over;
    logic is_get;
    logic is_del;
    logic is_put;
    logic put_is_hit;
    logic locked;
    logic len_zero;
    logic cnt_last;
    logic out_free;
  } st_t;

endpackage
`default_nettype wire

/* rtl/core/dikvs_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dikvs channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dikvs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] key_number;
  logic        object_locked;
  logic [7:0]  put_length;
  logic [3:0]  word_index;
  logic [63:0] value_word;

  modport source (output valid, kind, key_number, object_locked, put_length,
                  word_index, value_word, input ready);
  modport sink   (input valid, kind, key_number, object_locked, put_length,
                  word_index, value_word, output ready);
endinterface

interface dikvs_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  response;
  logic [31:0] reply_key;
  logic [7:0]  reply_length;
  logic [63:0] reply_word;
  logic        last_word;

  modport source (output valid, response, reply_key, reply_length, reply_word,
                  last_word, input ready);
  modport sink   (input valid, response, reply_key, reply_length, reply_word,
                  last_word, output ready);
endinterface

interface dikvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/dikvs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dikvs_ctrl
// Sequencer: clearing pass, request evaluation, decision and get streaming.
// ----------------------------------------------------------------------------
module dikvs_ctrl
  import dikvs_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  st_t  st_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_GET    = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.resp = RESP_GET_FAIL;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_IDLE;
        if (st_i.is_tick) begin
          cmd_o.tick_clear = 1'b1;
        end else if (st_i.is_cont) begin
          if (!st_i.cont_skip) state_d = S_DECIDE;
        end else if (st_i.key_bad || st_i.rate_over) begin
          cmd_o.put_close = st_i.is_put;
        end else begin
          cmd_o.rate_inc = 1'b1;
          if (st_i.is_get || st_i.is_del || st_i.is_put) state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st_i.is_cont) begin
          // store the word; a hit put also echoes it
          if (!st_i.cont_hit) begin
            cmd_o.cont_wr = 1'b1;
            state_d       = S_IDLE;
          end else if (st_i.out_free) begin
            cmd_o.cont_wr = 1'b1;
            cmd_o.emit    = 1'b1;
            cmd_o.resp    = RESP_PUT_HIT;
            state_d       = S_IDLE;
          end
        end else if (st_i.is_get) begin
          if (!st_i.len_zero) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_GET;
          end else if (st_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.resp = RESP_GET_FAIL;
            state_d    = S_IDLE;
          end
        end else if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          if (st_i.is_del) begin
            if (st_i.locked || st_i.len_zero) begin
              cmd_o.resp = RESP_DEL_FAIL;
            end else begin
              cmd_o.len_clr = 1'b1;
              cmd_o.resp    = RESP_DEL_OK;
            end
          end else begin
            if (st_i.locked || !st_i.len_zero) begin
              cmd_o.put_close = 1'b1;
              cmd_o.resp      = RESP_PUT_FAIL;
            end else begin
              cmd_o.put_open = 1'b1;
              cmd_o.resp     = st_i.put_is_hit ? RESP_PUT_HIT : RESP_PUT_MISS;
            end
          end
        end
      end
      S_GET: begin
        if (st_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.resp    = RESP_GET_OK;
          cmd_o.cnt_inc = 1'b1;
          if (st_i.cnt_last) state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/dikvs_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dikvs_dp
// Datapath: request register, length and word memories, rate counter,
// open-put tracking and the output register.
// ----------------------------------------------------------------------------
module dikvs_dp
  import dikvs_pkg::*;
#(
  parameter int TABLE_ENTRIES = DefTableEntries,
  parameter int VALUE_WORDS   = DefValueWords
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  req_t        req_i,
  input  wire         cfg_we_i,
  input  wire  [23:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output st_t         st_o,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output rsp_t        out_data_o
);

  localparam int EB    = $clog2(TABLE_ENTRIES);
  localparam int WB    = (VALUE_WORDS > 1) ? $clog2(VALUE_WORDS) : 1;
  localparam int AW    = EB + WB;
  localparam int WDEPTH = TABLE_ENTRIES * (2 ** WB);

  localparam logic [AW-1:0] CLR_LAST  = AW'(WDEPTH - 1);
  localparam logic [4:0]    VW_COUNT  = 5'(VALUE_WORDS);
  localparam logic [4:0]    VW_LAST   = 5'(VALUE_WORDS - 1);
  localparam logic [WB-1:0] CNT_LAST  = WB'(VALUE_WORDS - 1);
  localparam logic [31:0]   KEY_LIMIT = 32'(TABLE_ENTRIES);

  localparam logic [1:0] PUT_NONE = 2'd0;
  localparam logic [1:0] PUT_HIT  = 2'd2;
  localparam logic [1:0] PUT_MISS = 2'd3;

  logic [7:0]  len_mem  [TABLE_ENTRIES];
  logic [63:0] word_mem [WDEPTH];

  req_t          req_q;
  logic [AW-1:0] clr_q;
  logic [23:0]   limit_q, served_q;
  logic [1:0]    outcome_q;
  logic [EB-1:0] put_entry_q;
  logic [WB-1:0] cnt_q, cnt_d;
  logic [7:0]    len_q;
  logic [63:0]   wd_q;
  logic          out_valid_q;
  rsp_t          out_q, out_d;

  logic          is_put, is_cont, cont_last;
  logic [EB-1:0] key_entry, len_rd_addr;
  logic [4:0]    widx_ext;

  assign key_entry = req_q.key_number[EB-1:0];
  assign widx_ext  = {1'b0, req_q.word_index};
  assign is_put    = (req_q.kind == KIND_PUT_HIT) || (req_q.kind == KIND_PUT_MISS);
  assign is_cont   = is_put && (req_q.word_index != 4'd0);
  assign cont_last = (widx_ext == VW_LAST);

  assign st_o.clr_done   = (clr_q == CLR_LAST);
  assign st_o.is_tick    = (req_q.kind == KIND_TICK);
  assign st_o.is_cont    = is_cont;
  assign st_o.cont_skip  = (outcome_q == PUT_NONE) || (widx_ext >= VW_COUNT);
  assign st_o.cont_hit   = (outcome_q == PUT_HIT);
  assign st_o.key_bad    = (req_q.key_number >= KEY_LIMIT);
  assign st_o.rate_over  = (served_q >= limit_q);
  assign st_o.is_get     = (req_q.kind == KIND_GET) || (req_q.kind == KIND_GET_RESEND);
  assign st_o.is_del     = (req_q.kind == KIND_DELETE);
  assign st_o.is_put     = is_put;
  assign st_o.put_is_hit = (req_q.kind == KIND_PUT_HIT);
  assign st_o.locked     = req_q.object_locked;
  assign st_o.len_zero   = (len_q == 8'd0);
  assign st_o.cnt_last   = (cnt_q == CNT_LAST);
  assign st_o.out_free   = !out_valid_q || out_ready_i;

  // request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      limit_q     <= LIMIT_AT_RESET;
      served_q    <= '0;
      outcome_q   <= PUT_NONE;
      put_entry_q <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step && !st_o.clr_done) clr_q <= clr_q + AW'(1);
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (cmd_i.tick_clear) begin
        served_q <= '0;
      end else if (cmd_i.rate_inc) begin
        served_q <= served_q + 24'd1;
      end
      if (cmd_i.put_close || (cmd_i.cont_wr && cont_last)) begin
        outcome_q <= PUT_NONE;
      end else if (cmd_i.put_open) begin
        put_entry_q <= key_entry;
        if (VALUE_WORDS == 1) begin
          outcome_q <= PUT_NONE;
        end else begin
          outcome_q <= st_o.put_is_hit ? PUT_HIT : PUT_MISS;
        end
      end
      cnt_q <= cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + WB'(1);
    end
  end

  // length memory: one write port, one registered read
  assign len_rd_addr = is_cont ? put_entry_q : key_entry;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && (clr_q[WB-1:0] == '0)) begin
      len_mem[clr_q[AW-1:WB]] <= LEN_AT_RESET;
    end else if (cmd_i.len_clr) begin
      len_mem[key_entry] <= 8'd0;
    end else if (cmd_i.put_open) begin
      len_mem[key_entry] <= req_q.put_length;
    end
    len_q <= len_mem[len_rd_addr];
  end

  // word memory: one write port, one registered read that follows the
  // streaming counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      word_mem[clr_q] <= 64'd0;
    end else if (cmd_i.put_open) begin
      word_mem[{key_entry, {WB{1'b0}}}] <= req_q.value_word;
    end else if (cmd_i.cont_wr) begin
      word_mem[{put_entry_q, req_q.word_index[WB-1:0]}] <= req_q.value_word;
    end
    wd_q <= word_mem[{key_entry, cnt_d}];
  end

  // output register: build the reply item, load it on emit
  always_comb begin
    out_d.response     = cmd_i.resp;
    out_d.reply_key    = req_q.key_number;
    out_d.reply_length = 8'd0;
    out_d.reply_word   = 64'd0;
    out_d.last_word    = 1'b1;
    unique case (cmd_i.resp)
      RESP_GET_OK: begin
        out_d.reply_length = len_q;
        out_d.reply_word   = wd_q;
        out_d.last_word    = st_o.cnt_last;
      end
      RESP_PUT_HIT: begin
        out_d.reply_word = req_q.value_word;
        if (is_cont) begin
          out_d.reply_key    = 32'(put_entry_q);
          out_d.reply_length = len_q;
          out_d.last_word    = cont_last;
        end else begin
          out_d.reply_length = req_q.put_length;
          out_d.last_word    = (VALUE_WORDS == 1);
        end
      end
      default: begin
        out_d.last_word = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* rtl/core/direct_indexed_kv_store.sv */
`default_nettype none
// Requests: the store takes a new request item only after it is through with
//   the last one; a get ok streams VALUE_WORDS items, one per cycle while the
//   reply side takes them.
// Reset: a clearing pass over all TABLE_ENTRIES * 2**ceil(log2(VALUE_WORDS))
//   word-memory entries (16384 by default) takes no items; configuration writes
//   are always taken.
// ----------------------------------------------------------------------------
// direct_indexed_kv_store
// Key-value table addressed by key number, with get, delete and put requests
// and a per-second request limit cleared by tick items.
// ----------------------------------------------------------------------------
module direct_indexed_kv_store
  import dikvs_pkg::*;
#(
  parameter int TABLE_ENTRIES = DefTableEntries,
  parameter int VALUE_WORDS   = DefValueWords
) (
  input wire          clk_i,
  input wire          rst_ni,
  dikvs_req_if.sink   req_i,
  dikvs_rsp_if.source rsp_o,
  dikvs_cfg_if.sink   cfg_i
);

  cmd_t cmd;
  st_t  st;
  req_t req;
  rsp_t rsp;
  logic in_ready;

  // pack the request channel into one word for the request register
  assign req.kind          = req_i.kind;
  assign req.key_number    = req_i.key_number;
  assign req.object_locked = req_i.object_locked;
  assign req.put_length    = req_i.put_length;
  assign req.word_index    = req_i.word_index;
  assign req.value_word    = req_i.value_word;
  assign req_i.ready       = in_ready;

  // the limit register takes a write on any cycle
  assign cfg_i.ready = 1'b1;

  dikvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  dikvs_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .VALUE_WORDS   (VALUE_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (rsp)
  );

  // drive the response channel from the output register
  assign rsp_o.response     = rsp.response;
  assign rsp_o.reply_key    = rsp.reply_key;
  assign rsp_o.reply_length = rsp.reply_length;
  assign rsp_o.reply_word   = rsp.reply_word;
  assign rsp_o.last_word    = rsp.last_word;

endmodule
`default_nettype wire

/* test/dikvs_reply_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dikvs_reply_checker
// Watches the request, reply and configuration channels of the key-value
// store, keeps its own copy of the table and rate counter, and matches every
// reply item against the next one due.
// ----------------------------------------------------------------------------
module dikvs_reply_checker
  import dikvs_pkg::*;
#(
  parameter int TABLE_ENTRIES = DefTableEntries,
  parameter int VALUE_WORDS   = DefValueWords
) (
  input wire   clk_i,
  input wire   rst_ni,
  dikvs_req_if req_i,
  dikvs_rsp_if rsp_i,
  dikvs_cfg_if cfg_i,
  output int   mismatch_count_o,
  output int   replies_due_o
);

  localparam int PrintCap = 40;

  typedef enum logic [1:0] {
    PUT_IDLE,
    PUT_HIT_OPEN,
    PUT_MISS_OPEN
  } put_mode_e;

  logic [23:0] rate_limit;
  logic [23:0] rate_used;
  logic [7:0]  slot_len  [TABLE_ENTRIES];
  logic [63:0] slot_word [TABLE_ENTRIES * VALUE_WORDS];
  put_mode_e   put_mode;
  int          put_slot;
  rsp_t        kv_replies_due[$];
  int          mismatches;

  task automatic report(input string msg);
    if (mismatches < PrintCap) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic void queue_reply(input resp_e code, input logic [31:0] key,
                                      input logic [7:0] len, input logic [63:0] word,
                                      input logic last);
    rsp_t item;
    item.response     = code;
    item.reply_key    = key;
    item.reply_length = len;
    item.reply_word   = word;
    item.last_word    = last;
    kv_replies_due.push_back(item);
  endfunction

  function automatic void serve_request(input logic [2:0] kind, input logic [31:0] key,
                                        input logic locked, input logic [7:0] len,
                                        input logic [3:0] idx, input logic [63:0] word);
    bit is_put;
    int slot;
    int widx;
    is_put = (kind == KIND_PUT_HIT) || (kind == KIND_PUT_MISS);
    widx   = int'(idx);
    if (kind == KIND_TICK) begin
      rate_used = '0;
      return;
    end
    // continuation word of an open put
    if (is_put && widx != 0) begin
      if (put_mode == PUT_IDLE || widx >= VALUE_WORDS) return;
      slot_word[put_slot * VALUE_WORDS + widx] = word;
      if (put_mode == PUT_HIT_OPEN) begin
        queue_reply(RESP_PUT_HIT, 32'(put_slot), slot_len[put_slot], word,
                    widx == VALUE_WORDS - 1);
      end
      if (widx == VALUE_WORDS - 1) put_mode = PUT_IDLE;
      return;
    end
    // out-of-range key or over the limit: drop, closing any open put
    if (64'(key) >= 64'(TABLE_ENTRIES) || rate_used >= rate_limit) begin
      if (is_put) put_mode = PUT_IDLE;
      return;
    end
    slot      = int'(key);
    rate_used = rate_used + 24'd1;
    if (kind == KIND_GET || kind == KIND_GET_RESEND) begin
      if (slot_len[slot] == '0) begin
        queue_reply(RESP_GET_FAIL, key, '0, '0, 1'b1);
      end else begin
        for (int i = 0; i < VALUE_WORDS; i++) begin
          queue_reply(RESP_GET_OK, key, slot_len[slot], slot_word[slot * VALUE_WORDS + i],
                      i == VALUE_WORDS - 1);
        end
      end
    end else if (kind == KIND_DELETE) begin
      if (locked || slot_len[slot] == '0) begin
        queue_reply(RESP_DEL_FAIL, key, '0, '0, 1'b1);
      end else begin
        slot_len[slot] = '0;
        queue_reply(RESP_DEL_OK, key, '0, '0, 1'b1);
      end
    end else if (is_put) begin
      if (locked || slot_len[slot] != '0) begin
        put_mode = PUT_IDLE;
        queue_reply(RESP_PUT_FAIL, key, '0, '0, 1'b1);
      end else begin
        slot_len[slot]                 = len;
        slot_word[slot * VALUE_WORDS]  = word;
        put_slot                       = slot;
        if (kind == KIND_PUT_HIT) begin
          put_mode = (VALUE_WORDS == 1) ? PUT_IDLE : PUT_HIT_OPEN;
          queue_reply(RESP_PUT_HIT, key, len, word, VALUE_WORDS == 1);
        end else begin
          put_mode = (VALUE_WORDS == 1) ? PUT_IDLE : PUT_MISS_OPEN;
          queue_reply(RESP_PUT_MISS, key, '0, '0, 1'b1);
        end
      end
    end
    // other kinds only use up rate
  endfunction

  task automatic match_reply();
    rsp_t want;
    if (kv_replies_due.size() == 0) begin
      report($sformatf("unexpected reply resp=%0d key=%0d len=%0d word=%h last=%b",
                       rsp_i.response, rsp_i.reply_key, rsp_i.reply_length,
                       rsp_i.reply_word, rsp_i.last_word));
    end else begin
      want = kv_replies_due.pop_front();
      if (rsp_i.response !== want.response || rsp_i.reply_key !== want.reply_key ||
          rsp_i.reply_length !== want.reply_length ||
          rsp_i.reply_word !== want.reply_word || rsp_i.last_word !== want.last_word) begin
        report($sformatf({"reply resp=%0d key=%0d len=%0d word=%h last=%b, ",
                          "want resp=%0d key=%0d len=%0d word=%h last=%b"},
                         rsp_i.response, rsp_i.reply_key, rsp_i.reply_length,
                         rsp_i.reply_word, rsp_i.last_word, want.response,
                         want.reply_key, want.reply_length, want.reply_word,
                         want.last_word));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_limit = LIMIT_AT_RESET;
      rate_used  = '0;
      put_mode   = PUT_IDLE;
      put_slot   = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_len[i] = LEN_AT_RESET;
      for (int i = 0; i < TABLE_ENTRIES * VALUE_WORDS; i++) slot_word[i] = '0;
      kv_replies_due.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) rate_limit = cfg_i.data;
      if (req_i.valid && req_i.ready) begin
        serve_request(req_i.kind, req_i.key_number, req_i.object_locked,
                      req_i.put_length, req_i.word_index, req_i.value_word);
      end
      if (rsp_i.valid && rsp_i.ready) match_reply();
    end
    replies_due_o    <= kv_replies_due.size();
    mismatch_count_o <= mismatches;
  end

  initial mismatches = 0;

endmodule
`default_nettype wire

/* test/tb_direct_indexed_kv_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_direct_indexed_kv_store
// Drives requests and rate-limit writes into the key-value store, stalls the
// reply side at random, and lets the reply checker judge every reply item.
// ----------------------------------------------------------------------------
module tb_direct_indexed_kv_store;
  import dikvs_pkg::*;

  localparam logic [2:0] KIND_OTHER    = 3'd6;
  localparam logic [2:0] KIND_RESERVED = 3'd7;

  // Quiet cycles allowed: covers the clearing pass after reset, which takes no items.
  localparam int WATCHDOG_LIMIT = 100000;
  // Cycles to let pass once nothing is due: covers a dropped or silent item
  // still in flight.
  localparam int SETTLE_CYCLES  = 2 * DefValueWords + 8;
  // Length of the single long reply stall that backs the store up.
  localparam int LONG_HOLD      = 400;

  logic clk;
  logic rst_n;

  dikvs_req_if req_ch ();
  dikvs_rsp_if rsp_ch ();
  dikvs_cfg_if cfg_ch ();

  int mismatches;
  int replies_due;
  int items_sent;
  bit quick_sender;
  bit hold_replies;

  direct_indexed_kv_store dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  dikvs_reply_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_i            (req_ch),
    .rsp_i            (rsp_ch),
    .cfg_i            (cfg_ch),
    .mismatch_count_o (mismatches),
    .replies_due_o    (replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly a handful of slots so that deletes, puts and gets meet each other.
  function automatic logic [31:0] pool_key();
    if ($urandom_range(0, 9) == 0) return 32'(DefTableEntries - 1);
    return 32'($urandom_range(0, 7));
  endfunction

  // Any key: pool, whole table, or out of range.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: begin
        return 32'($urandom_range(0, DefTableEntries - 1));
      end
      1: begin
        return $urandom | 32'(DefTableEntries);
      end
      default: begin
        return pool_key();
      end
    endcase
  endfunction

  // Offer one item; keep valid high into the next item when no gap is drawn.
  task automatic offer(input logic [2:0] kind, input logic [31:0] key,
                       input logic locked, input logic [7:0] len,
                       input logic [3:0] idx, input logic [63:0] word);
    int gap;
    gap = quick_sender ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.key_number    <= key;
    req_ch.object_locked <= locked;
    req_ch.put_length    <= len;
    req_ch.word_index    <= idx;
    req_ch.value_word    <= word;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Drop valid, wait for every reply due, then let in-flight silent items finish.
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (replies_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] limit);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= limit;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic noise_item();
    offer(3'($urandom_range(0, 7)), pick_key(), 1'($urandom_range(0, 1)),
          8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), rand_word());
  endtask

  task automatic get_item(input logic [31:0] key);
    offer($urandom_range(0, 1) ? KIND_GET : KIND_GET_RESEND, key,
          1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), '0, rand_word());
  endtask

  // Open a put and stream its words; some words go missing, some puts stop
  // early, and now and then another request cuts into the stream.
  task automatic put_sequence(input logic [31:0] key);
    logic [2:0] kind;
    int         stop_at;
    kind    = $urandom_range(0, 1) ? KIND_PUT_HIT : KIND_PUT_MISS;
    stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, DefValueWords - 1)
                                          : DefValueWords - 1;
    offer(kind, key, $urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)), '0,
          rand_word());
    for (int i = 1; i <= stop_at; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 3))
          0: get_item(pick_key());
          1: offer(KIND_TICK, pick_key(), 1'b0, '0, '0, rand_word());
          2: offer(kind, $urandom | 32'(DefTableEntries), 1'b0, '0, '0, rand_word());
          default: noise_item();
        endcase
      end
      // continuation words ignore everything but the index and the word
      if ($urandom_range(0, 9) != 0) begin
        offer($urandom_range(0, 1) ? KIND_PUT_HIT : KIND_PUT_MISS, $urandom,
              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 4'(i), rand_word());
      end
    end
  endtask

  task automatic run_random(input int count);
    int          target;
    logic [31:0] key;
    target = items_sent + count;
    while (items_sent < target) begin
      quick_sender = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // well-formed: free the slot, fill it, read it back
          key = pool_key();
          offer(KIND_DELETE, key, $urandom_range(0, 7) == 0, '0, '0, rand_word());
          put_sequence(key);
          if ($urandom_range(0, 1)) get_item(key);
        end
        3, 4: get_item(pick_key());
        5: offer(KIND_DELETE, pick_key(), $urandom_range(0, 3) == 0, '0, '0, rand_word());
        6: offer(KIND_TICK, pick_key(), 1'($urandom_range(0, 1)), '0, '0, rand_word());
        7: put_sequence(pick_key());
        default: noise_item();
      endcase
    end
  endtask

  // Reply side: draw a stall before each item, with runs of no stall and one
  // long hold-off when asked.
  initial begin : reply_sink
    int gap;
    bit quick;
    quick = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) quick = !quick;
      gap = quick ? 0 : $urandom_range(0, 19);
      if (hold_replies) begin
        gap          = LONG_HOLD;
        hold_replies = 1'b0;
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // End the run when no channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("[direct_indexed_kv_store] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] ones;
    ones         = '1;
    items_sent   = 0;
    quick_sender = 1'b0;
    hold_replies = 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.kind          <= KIND_TICK;
    req_ch.key_number    <= '0;
    req_ch.object_locked <= 1'b0;
    req_ch.put_length    <= '0;
    req_ch.word_index    <= '0;
    req_ch.value_word    <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.data          <= '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass with the limit wide open.
    write_limit(24'hFFFFFF);
    offer(KIND_GET, 32'd0, 1'b0, '0, '0, '0);             // full at reset: zero words
    offer(KIND_PUT_HIT, 32'd0, 1'b0, 8'd5, '0, ones);     // slot not empty: put fails
    offer(KIND_PUT_HIT, 32'd0, 1'b0, '0, 4'd1, ones);     // no put open: ignored
    offer(KIND_DELETE, 32'd0, 1'b1, '0, '0, '0);          // locked
    offer(KIND_DELETE, 32'd0, 1'b0, '0, '0, '0);
    offer(KIND_DELETE, 32'd0, 1'b0, '0, '0, '0);          // already empty
    offer(KIND_GET, 32'd0, 1'b0, '0, '0, '0);             // empty: get fails
    offer(KIND_PUT_HIT, 32'd0, 1'b1, 8'd9, '0, ones);     // locked put
    offer(KIND_PUT_HIT, 32'd0, 1'b0, 8'd255, '0, ones);   // echoing put, some words missing
    offer(KIND_PUT_MISS, 32'hFFFFFFFF, 1'b1, 8'd255, 4'd1, rand_word());
    offer(KIND_PUT_HIT, 32'd0, 1'b0, '0, 4'd2, rand_word());
    offer(KIND_PUT_HIT, 32'd0, 1'b0, '0, 4'd15, ones);    // last word closes the put
    offer(KIND_GET_RESEND, 32'd0, 1'b1, '0, 4'd15, ones);
    offer(KIND_DELETE, 32'(DefTableEntries - 1), 1'b0, '0, '0, '0);
    offer(KIND_PUT_MISS, 32'(DefTableEntries - 1), 1'b0, 8'd0, '0, rand_word());
    offer(KIND_PUT_MISS, 32'd0, 1'b0, '0, 4'd5, rand_word());
    offer(KIND_PUT_MISS, 32'd0, 1'b0, '0, 4'd15, rand_word());
    offer(KIND_GET, 32'(DefTableEntries - 1), 1'b0, '0, '0, '0);  // stored length 0
    offer(KIND_GET, 32'(DefTableEntries), 1'b0, '0, '0, '0);      // out of range
    offer(KIND_GET, 32'hFFFFFFFF, 1'b0, '0, '0, '0);
    offer(KIND_TICK, 32'hFFFFFFFF, 1'b1, 8'd255, 4'd15, ones);
    offer(KIND_OTHER, 32'd3, 1'b0, '0, '0, '0);
    offer(KIND_RESERVED, 32'd3, 1'b1, '0, '0, '0);
    offer(KIND_PUT_HIT, 32'd4, 1'b0, '0, 4'd3, ones);             // stray continuation

    // Limit zero: every request drops, ticks and stray words change nothing.
    write_limit(24'd0);
    offer(KIND_GET, 32'd0, 1'b0, '0, '0, '0);
    offer(KIND_PUT_MISS, 32'd3, 1'b0, 8'd7, '0, rand_word());
    offer(KIND_PUT_MISS, 32'd3, 1'b0, '0, 4'd4, rand_word());
    offer(KIND_TICK, 32'd0, 1'b0, '0, '0, '0);
    offer(KIND_DELETE, 32'd2, 1'b0, '0, '0, '0);
    offer(KIND_OTHER, 32'd2, 1'b0, '0, '0, '0);

    // Tight limit: many requests drop between ticks.
    write_limit(24'($urandom_range(2, 6)));
    run_random(80);

    // Loose limit; back the store up behind one long reply stall first.
    write_limit(24'($urandom_range(1000, 24'hFFFFFE)));
    hold_replies = 1'b1;
    quick_sender = 1'b1;
    repeat (8) get_item(pool_key());
    run_random(70);
    settle();
    run_random(70);

    settle();
    if (mismatches == 0) begin
      $display("[direct_indexed_kv_store] OK");
    end else begin
      $display("[direct_indexed_kv_store] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
